// ----- hw/rtl/pipc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pipc_pkg;

    // default coordinate format, signed fixed point
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    // offset radius register width, unsigned
    localparam int RADIUS_WIDTH = 16;

    // edge unit to top: one edge finished, and whether it flips the parity
    typedef struct packed {
        logic done;
        logic toggle;
    } pipc_edge_status_t;

    // serial compare engine to edge unit: finished, and sign of the difference
    typedef struct packed {
        logic done;
        logic neg;
    } pipc_cmp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pipc_serial_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sign of mult_a*mcand_a - mult_b*mcand_b, one multiplier bit per cycle,
// lsb first; the low product bits drop out of a narrow accumulator
module pipc_serial_cmp
    import pipc_pkg::*;
#(
    parameter int MCAND_WIDTH = COORD_WIDTH_DEF,
    parameter int MULT_WIDTH  = COORD_WIDTH_DEF + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [MULT_WIDTH-1:0]  mult_a,
    input  logic [MULT_WIDTH-1:0]  mult_b,
    input  logic [MCAND_WIDTH-1:0] mcand_a,
    input  logic [MCAND_WIDTH-1:0] mcand_b,
    output pipc_cmp_status_t       status
);

    localparam int AW = MCAND_WIDTH + 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                  state_reg;
    pipc_cmp_status_t        status_reg;
    logic [MULT_WIDTH-1:0]   a_sr_reg;
    logic [MULT_WIDTH-1:0]   b_sr_reg;
    logic [MCAND_WIDTH-1:0]  ma_reg;
    logic [MCAND_WIDTH-1:0]  mb_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [AW:0]      sum;
    logic signed [AW:0]      add_a;
    logic signed [AW:0]      add_b;
    logic                    bits_left;

    assign bits_left = (a_sr_reg != '0) || (b_sr_reg != '0);

    always_comb
    begin
        add_a = a_sr_reg[0] ? $signed({2'b00, ma_reg}) : '0;
        add_b = b_sr_reg[0] ? $signed({2'b00, mb_reg}) : '0;
        sum   = $signed({acc_reg[AW-1], acc_reg}) + add_a - add_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            status_reg <= '0;
        end
        else
        begin
            status_reg.done <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    // remaining steps would only shift right, the sign is final
                    if (!bits_left)
                    begin
                        status_reg.done <= 1'b1;
                        status_reg.neg  <= acc_reg[AW-1];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            a_sr_reg <= mult_a;
            b_sr_reg <= mult_b;
            ma_reg   <= mcand_a;
            mb_reg   <= mcand_b;
            acc_reg  <= '0;
        end
        else if (state_reg == ST_RUN && bits_left)
        begin
            acc_reg  <= sum[AW:1];
            a_sr_reg <= a_sr_reg >> 1;
            b_sr_reg <= b_sr_reg >> 1;
        end
    end

    assign status = status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pipc_edge_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one polygon edge: straddle check, then the crossing compare
// tx - r < xi + trunc(dx*dyt/dy) turned into a sign test of two products
module pipc_edge_unit
    import pipc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] xi,
    input  logic signed [COORD_WIDTH-1:0] yi,
    input  logic signed [COORD_WIDTH-1:0] xj,
    input  logic signed [COORD_WIDTH-1:0] yj,
    input  logic signed [COORD_WIDTH-1:0] tx,
    input  logic signed [COORD_WIDTH-1:0] ty,
    input  logic [RADIUS_WIDTH-1:0]       radius,
    output pipc_edge_status_t             status
);

    localparam int EW = ((COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH) + 2;
    localparam int KW = EW - 1;
    localparam int DW = COORD_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WAIT
    } state_t;

    function automatic logic [COORD_WIDTH-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(-v) : DW'(v);
        return m[COORD_WIDTH-1:0];
    endfunction

    state_t                  state_reg;
    pipc_edge_status_t       status_reg;
    logic                    eng_start_reg;
    pipc_cmp_status_t        cmp_st;

    logic signed [EW-1:0]    r_e;
    logic signed [EW-1:0]    ty_r;
    logic                    below_i;
    logic                    below_j;

    logic                    strad_reg;
    logic signed [DW-1:0]    dx_reg;
    logic signed [DW-1:0]    dyt_reg;
    logic signed [DW-1:0]    dy_reg;
    logic signed [EW-1:0]    tdiff_reg;
    logic                    neg_reg;
    logic [KW-1:0]           mult_a_reg;
    logic [KW-1:0]           mult_b_reg;
    logic [COORD_WIDTH-1:0]  mcand_a_reg;
    logic [COORD_WIDTH-1:0]  mcand_b_reg;

    logic                    neg;
    logic                    t_neg;
    logic [EW-1:0]           tplus;
    logic [EW-1:0]           tminus;

    // level of the ray and straddle flags, exact
    always_comb
    begin
        r_e     = $signed({{(EW - RADIUS_WIDTH){1'b0}}, radius});
        ty_r    = EW'(ty) + r_e;
        below_i = EW'(yi) < ty_r;
        below_j = EW'(yj) < ty_r;
    end

    // sign of the quotient and the integer bound k
    always_comb
    begin
        neg    = dx_reg[DW-1] ^ dyt_reg[DW-1] ^ dy_reg[DW-1];
        t_neg  = tdiff_reg[EW-1];
        tplus  = tdiff_reg + {{(EW - 1){1'b0}}, 1'b1};
        tminus = '0 - tdiff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            status_reg    <= '0;
            eng_start_reg <= 1'b0;
        end
        else
        begin
            status_reg.done <= 1'b0;
            eng_start_reg   <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    priority if (!strad_reg)
                    begin
                        status_reg <= '{done: 1'b1, toggle: 1'b0};
                        state_reg  <= ST_IDLE;
                    end
                    else if (!neg && t_neg)
                    begin
                        // crossing at or right of xi, test x strictly left
                        status_reg <= '{done: 1'b1, toggle: 1'b1};
                        state_reg  <= ST_IDLE;
                    end
                    else if (neg && !t_neg)
                    begin
                        status_reg <= '{done: 1'b1, toggle: 1'b0};
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        eng_start_reg <= 1'b1;
                        state_reg     <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (cmp_st.done)
                    begin
                        status_reg.done   <= 1'b1;
                        status_reg.toggle <= neg_reg ? cmp_st.neg : !cmp_st.neg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            strad_reg <= below_i ^ below_j;
            dx_reg    <= DW'(xj) - DW'(xi);
            dyt_reg   <= DW'(yi) - DW'(ty);
            dy_reg    <= DW'(yj) - DW'(yi);
            tdiff_reg <= EW'(tx) - r_e - EW'(xi);
        end
        if (state_reg == ST_SETUP)
        begin
            neg_reg     <= neg;
            mult_a_reg  <= KW'(mag(dx_reg));
            mult_b_reg  <= neg ? tminus[KW-1:0] : tplus[KW-1:0];
            mcand_a_reg <= mag(dyt_reg);
            mcand_b_reg <= mag(dy_reg);
        end
    end

    pipc_serial_cmp #(
        .MCAND_WIDTH (COORD_WIDTH),
        .MULT_WIDTH  (KW)
    ) u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eng_start_reg),
        .mult_a  (mult_a_reg),
        .mult_b  (mult_b_reg),
        .mcand_a (mcand_a_reg),
        .mcand_b (mcand_b_reg),
        .status  (cmp_st)
    );

    assign status = status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/point_in_polygon_crossing.sv -----
`timescale 1ns / 1ps
`default_nettype none

// a first vertex is just stored; each later one starts the edge from the previous vertex,
//   decided by straddle and sign or by the serial compare of K = max(COORD_WIDTH, 16) + 1
//   (25) bits; the last vertex adds the closing edge, then the result goes out
// throughput: one item at a time, the compare stops once the multiplier bits are zero;
//   a new result waits in place while the previous one is still held by m_tready
// reset: rst_n async active low; clears parity, have_vertex, output valid; radius 0.5
module point_in_polygon_crossing
    import pipc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items, one polygon vertex each
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vertex_x, vertex_y, test_x, test_y from the lowest bit up, zero filled
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // last_vertex
    input  logic                                s_tlast,
    // result items, one per polygon
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // inside_res in bit 0, zero filled
    output logic [7:0]                          m_tdata,
    // offset_radius write
    input  logic                                cfg_we,
    input  logic [RADIUS_WIDTH-1:0]             cfg_wdata
);

    localparam int W = COORD_WIDTH;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET =
        RADIUS_WIDTH'((32'd1 << FRAC_BITS) >> 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_EDGE1,
        ST_EDGE2,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic                   have_vertex_reg;
    logic                   parity_reg;
    logic                   m_tvalid_reg;
    logic                   inside_reg;
    logic [RADIUS_WIDTH-1:0] radius_reg;

    // current item and polygon memory
    logic signed [W-1:0]    cur_x_reg;
    logic signed [W-1:0]    cur_y_reg;
    logic signed [W-1:0]    tx_reg;
    logic signed [W-1:0]    ty_reg;
    logic                   last_reg;
    logic signed [W-1:0]    first_x_reg;
    logic signed [W-1:0]    first_y_reg;
    logic signed [W-1:0]    prev_x_reg;
    logic signed [W-1:0]    prev_y_reg;

    // edge unit hookup
    logic                   edge_start;
    logic                   sel_close;
    logic signed [W-1:0]    e_xi;
    logic signed [W-1:0]    e_yi;
    logic signed [W-1:0]    e_xj;
    logic signed [W-1:0]    e_yj;
    pipc_edge_status_t      edge_st;

    logic                   s_fire;
    logic                   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // edge from the previous vertex on launch, closing edge after the first test
    assign sel_close  = (state_reg == ST_EDGE1);
    assign e_xi       = sel_close ? cur_x_reg   : prev_x_reg;
    assign e_yi       = sel_close ? cur_y_reg   : prev_y_reg;
    assign e_xj       = sel_close ? first_x_reg : cur_x_reg;
    assign e_yj       = sel_close ? first_y_reg : cur_y_reg;
    assign edge_start = (state_reg == ST_LAUNCH && have_vertex_reg) ||
                        (state_reg == ST_EDGE1 && edge_st.done && last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_vertex_reg <= 1'b0;
            parity_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            inside_reg      <= 1'b0;
            radius_reg      <= RADIUS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH:
                begin
                    if (!have_vertex_reg)
                    begin
                        // first vertex of a polygon, no edge yet; a lone
                        // vertex has a degenerate closing edge, parity stays 0
                        have_vertex_reg <= 1'b1;
                        parity_reg      <= 1'b0;
                        state_reg       <= last_reg ? ST_RESULT : ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_EDGE1;
                    end
                end
                ST_EDGE1:
                begin
                    if (edge_st.done)
                    begin
                        parity_reg <= parity_reg ^ edge_st.toggle;
                        state_reg  <= last_reg ? ST_EDGE2 : ST_IDLE;
                    end
                end
                ST_EDGE2:
                begin
                    if (edge_st.done)
                    begin
                        parity_reg <= parity_reg ^ edge_st.toggle;
                        state_reg  <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    // wait for the output register, then start a new polygon
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        inside_reg      <= parity_reg;
                        parity_reg      <= 1'b0;
                        have_vertex_reg <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cur_x_reg <= $signed(s_tdata[W-1:0]);
            cur_y_reg <= $signed(s_tdata[2*W-1:W]);
            tx_reg    <= $signed(s_tdata[3*W-1:2*W]);
            ty_reg    <= $signed(s_tdata[4*W-1:3*W]);
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_LAUNCH)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            if (!have_vertex_reg)
            begin
                first_x_reg <= cur_x_reg;
                first_y_reg <= cur_y_reg;
            end
        end
    end

    pipc_edge_unit #(
        .COORD_WIDTH (W)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (edge_start),
        .xi     (e_xi),
        .yi     (e_yi),
        .xj     (e_xj),
        .yj     (e_yj),
        .tx     (tx_reg),
        .ty     (ty_reg),
        .radius (radius_reg),
        .status (edge_st)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, inside_reg};

    // an edge result only comes back while an edge test is pending
    a_edge_done_in_test: assert property (@(posedge clk) disable iff (!rst_n)
        edge_st.done |-> (state_reg == ST_EDGE1 || state_reg == ST_EDGE2))
        else $error("edge result outside an edge test");

    // pushing a result ends the polygon
    a_result_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=>
        (m_tvalid_reg && !have_vertex_reg && state_reg == ST_IDLE))
        else $error("result push did not close the polygon");

    // no polygon open means no crossings counted
    a_parity_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !have_vertex_reg) |-> !parity_reg)
        else $error("parity left set between polygons");

endmodule

`default_nettype wire
